[hdl/sswv_pkg.sv]
// shared types and constants for the sample store with variance readout
`default_nettype none

package sswv_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int MIN_VAR_COUNT   = 4;
	localparam int IDX_W           = 6;
	localparam int CMD_W           = 2;
	localparam int CNT_OUT_W       = 7;
	localparam int VAR_W           = 63;
	// quotient bits retired per divide cycle
	localparam int DIV_R           = 4;

	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	typedef struct packed {
		logic             pad;
		logic [IDX_W-1:0] read_index;
		logic [31:0]      stamp_ms;
		logic             commit_flag;
		logic [31:0]      time_us;
	} in_item_t;

	typedef struct packed {
		logic [6:0]           pad;
		logic [VAR_W-1:0]     variance;
		logic [CNT_OUT_W-1:0] sample_count;
		logic [31:0]          read_stamp_ms;
		logic                 read_commit;
		logic [31:0]          read_time_us;
		logic                 entry_valid;
		logic                 accepted;
	} out_item_t;

	localparam int IN_W  = $bits(in_item_t);
	localparam int OUT_W = $bits(out_item_t);

endpackage

`default_nettype wire

[hdl/sample_store_with_variance_top.sv]
// sample store with exact population variance readout, top level
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata (sample, index), s_tuser (command)
//  m_       out  m_tvalid/m_tready  m_tdata (read entry, count, variance)
//  cfg_     in   cfg_valid/cfg_ready cfg_data (collect enable), always ready
//
// one request at a time; a stored sample's time is squared on the shared multiplier, then,
// with four or more samples, count*sq_sum - sum*sum is built from 32x32 partial products
// and divided by count*count in 20 steps of the radix-16 divider
// with fewer than four samples the variance is 0 and the multiply and divide are skipped
// the result sits in an output register; a new request is taken while it waits
// reset leaves the store empty and collection enabled; no clearing pass
`default_nettype none

module sample_store_with_variance_top #(
	parameter int STORE_DEPTH = sswv_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output      logic                      s_tready,
	// time_us[31:0], commit_flag[32], stamp_ms[64:33], read_index[70:65], zero[71]
	input  wire logic [sswv_pkg::IN_W-1:0]  s_tdata,
	// cmd[1:0]
	input  wire logic [sswv_pkg::CMD_W-1:0] s_tuser,
	output      logic                      m_tvalid,
	input  wire logic                      m_tready,
	// accepted[0], entry_valid[1], read_time_us[33:2], read_commit[34],
	// read_stamp_ms[66:35], sample_count[73:67], variance[136:74], zero[143:137]
	output      logic [sswv_pkg::OUT_W-1:0] m_tdata,
	input  wire logic                      cfg_valid,
	output      logic                      cfg_ready,
	// collect_enable[0]
	input  wire logic                      cfg_data
);

	localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int AW      = $clog2(STORE_DEPTH);
	localparam int SUM_W   = 32 + CNT_W;
	localparam int SQ_W    = 64 + CNT_W;
	localparam int NUM_W   = 64 + 2 * CNT_W;
	localparam int DIV_R   = sswv_pkg::DIV_R;
	localparam int ACC_W   = ((NUM_W + DIV_R - 1) / DIV_R) * DIV_R;
	localparam int D_W     = 2 * CNT_W;
	localparam int K2      = (SQ_W + 31) / 32;
	localparam int K1      = (SUM_W + 31) / 32;
	localparam int K2_IW   = $clog2(K2);
	localparam int K1_IW   = $clog2(K1);
	localparam int NSTEP   = K2 + K1 * K1;
	localparam int STEP_W  = $clog2(NSTEP + 1);
	localparam int SH_W    = $clog2(K2 + 2 * K1);
	localparam int DIV_CYC = ACC_W / DIV_R;
	localparam int DC_W    = $clog2(DIV_CYC);
	localparam int CMP_W   = (CNT_W > sswv_pkg::IDX_W) ? CNT_W : sswv_pkg::IDX_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	typedef struct packed {
		logic        commit;
		logic [31:0] stamp;
		logic [31:0] tm;
	} entry_t;

	sswv_pkg::in_item_t  in_w;
	sswv_pkg::out_item_t out_w;

	logic [2:0]              state_q;
	logic                    en_q;
	logic [CNT_W-1:0]        count_q;
	logic [SUM_W-1:0]        sum_q;
	logic [SQ_W-1:0]         sq_q;
	logic                    sq_pend_q;
	logic [31:0]             t_q;
	logic                    ok_q;
	logic                    ev_q;

	entry_t                  mem [STORE_DEPTH];
	entry_t                  rd_q;
	logic                    we;
	logic                    re;

	logic [STEP_W-1:0]       step_q;
	logic [K1_IW-1:0]        i_q;
	logic [K1_IW-1:0]        j_q;
	logic [DC_W-1:0]         dcnt_q;
	logic [ACC_W-1:0]        acc_q;
	logic [D_W-1:0]          rem_q;
	logic [D_W-1:0]          d_q;

	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [SH_W-1:0]         sh_nx;
	logic                    mac_nx;
	logic                    sub_nx;
	logic [63:0]             prod_s1;
	logic [SH_W-1:0]         sh_s1;
	logic                    mac_s1;
	logic                    sub_s1;

	logic [K2*32-1:0]        sq_ext;
	logic [K1*32-1:0]        sum_ext;
	logic [31:0]             sq_ch  [K2];
	logic [31:0]             sum_ch [K1];
	logic [ACC_W-1:0]        shifted;
	logic [ACC_W-1:0]        div_acc;
	logic [D_W-1:0]          div_rem;

	logic                    take;
	logic                    rec_ok;
	logic                    rd_ok;
	logic                    out_free;

	assign in_w      = sswv_pkg::in_item_t'(s_tdata);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign take      = s_tvalid && s_tready;
	assign rec_ok    = en_q && (count_q < CNT_W'(STORE_DEPTH));
	assign rd_ok     = CMP_W'(in_w.read_index) < CMP_W'(count_q);
	assign we        = take && (s_tuser == sswv_pkg::CMD_RECORD) && rec_ok;
	assign re        = take && (s_tuser == sswv_pkg::CMD_READ);
	assign out_free  = !m_tvalid || m_tready;

	// entry store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[count_q[AW-1:0]] <= '{commit: in_w.commit_flag, stamp: in_w.stamp_ms,
				tm: in_w.time_us};
		end
		if (re) begin
			rd_q <= mem[AW'(in_w.read_index)];
		end
	end

	// operand chunks for the shared multiplier
	always_comb begin
		sq_ext  = (K2*32)'(sq_q);
		sum_ext = (K1*32)'(sum_q);
		for (int k = 0; k < K2; k++) begin
			sq_ch[k] = sq_ext[k*32 +: 32];
		end
		for (int k = 0; k < K1; k++) begin
			sum_ch[k] = sum_ext[k*32 +: 32];
		end
	end

	// count*sq_sum adds, sum*sum subtracts, partial products by chunk
	always_comb begin
		mul_a  = t_q;
		mul_b  = t_q;
		sh_nx  = '0;
		mac_nx = 1'b0;
		sub_nx = 1'b0;
		if (state_q == ST_MUL) begin
			if (step_q < STEP_W'(K2)) begin
				mul_a  = 32'(count_q);
				mul_b  = sq_ch[step_q[K2_IW-1:0]];
				sh_nx  = SH_W'(step_q);
				mac_nx = 1'b1;
			end else if (step_q < STEP_W'(NSTEP)) begin
				mul_a  = sum_ch[i_q];
				mul_b  = sum_ch[j_q];
				sh_nx  = SH_W'(i_q) + SH_W'(j_q);
				mac_nx = 1'b1;
				sub_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_a) * 64'(mul_b);
		sh_s1   <= sh_nx;
		sub_s1  <= sub_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
		end else begin
			mac_s1 <= mac_nx;
		end
	end

	assign shifted = ACC_W'(prod_s1) << {sh_s1, 5'd0};

	// restoring divide, DIV_R quotient bits a cycle, quotient shifts into acc
	always_comb begin
		logic [D_W:0]     r;
		logic [ACC_W-1:0] a;
		r = {1'b0, rem_q};
		a = acc_q;
		for (int k = 0; k < DIV_R; k++) begin
			r = {r[D_W-1:0], a[ACC_W-1]};
			a = {a[ACC_W-2:0], 1'b0};
			if (r >= {1'b0, d_q}) begin
				r    = r - {1'b0, d_q};
				a[0] = 1'b1;
			end
		end
		div_acc = a;
		div_rem = r[D_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			t_q   <= in_w.time_us;
			ok_q  <= (s_tuser == sswv_pkg::CMD_RECORD) && rec_ok;
			ev_q  <= (s_tuser == sswv_pkg::CMD_READ) && rd_ok;
		end
		unique case (state_q)
			ST_PREP: begin
				acc_q <= '0;
				rem_q <= '0;
				d_q   <= D_W'(D_W'(count_q) * D_W'(count_q));
			end
			ST_DIV: begin
				acc_q <= div_acc;
				rem_q <= div_rem;
			end
			default: begin
				if (mac_s1) begin
					acc_q <= sub_s1 ? acc_q - shifted : acc_q + shifted;
				end
			end
		endcase
	end

	always_comb begin
		out_w              = '0;
		out_w.accepted     = ok_q;
		out_w.entry_valid  = ev_q;
		out_w.sample_count = sswv_pkg::CNT_OUT_W'(count_q);
		out_w.variance     = acc_q[sswv_pkg::VAR_W-1:0];
		if (ev_q) begin
			out_w.read_time_us  = rd_q.tm;
			out_w.read_commit   = rd_q.commit;
			out_w.read_stamp_ms = rd_q.stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tdata <= out_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			en_q      <= 1'b1;
			count_q   <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
			sq_pend_q <= 1'b0;
			step_q    <= '0;
			i_q       <= '0;
			j_q       <= '0;
			dcnt_q    <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				en_q <= cfg_data;
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						sq_pend_q <= 1'b0;
						state_q   <= ST_PREP;
						unique case (s_tuser)
							sswv_pkg::CMD_RECORD: begin
								if (rec_ok) begin
									count_q   <= count_q + 1'b1;
									sum_q     <= sum_q + SUM_W'(in_w.time_us);
									sq_pend_q <= 1'b1;
									state_q   <= ST_SQ;
								end
							end
							sswv_pkg::CMD_CLEAR: begin
								count_q <= '0;
								sum_q   <= '0;
								sq_q    <= '0;
							end
							sswv_pkg::CMD_READ, sswv_pkg::CMD_NOP: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_SQ: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					// prod_s1 holds time squared of a stored sample here
					if (sq_pend_q) begin
						sq_q <= sq_q + SQ_W'(prod_s1);
					end
					step_q <= '0;
					i_q    <= '0;
					j_q    <= '0;
					dcnt_q <= '0;
					if (count_q < CNT_W'(sswv_pkg::MIN_VAR_COUNT)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q >= STEP_W'(K2) && step_q < STEP_W'(NSTEP)) begin
						if (j_q == K1_IW'(K1 - 1)) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					// last product is added in this cycle
					if (step_q == STEP_W'(NSTEP)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DC_W'(DIV_CYC - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/sswv_checker.sv]
// port-level checks for the sample store, bound to the top level
`default_nettype none

module sswv_checker #(
	parameter int STORE_DEPTH = sswv_pkg::STORE_DEPTH_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [sswv_pkg::OUT_W-1:0] m_tdata
);

	sswv_pkg::out_item_t o;
	logic                small_depth;

	assign o           = sswv_pkg::out_item_t'(m_tdata);
	assign small_depth = (STORE_DEPTH < (1 << sswv_pkg::CNT_OUT_W));

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight: ready drops after each request
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while one is in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && small_depth |->
		o.sample_count <= sswv_pkg::CNT_OUT_W'(STORE_DEPTH))
		else $error("sample count beyond store depth");

	a_var_small: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && small_depth &&
		o.sample_count < sswv_pkg::CNT_OUT_W'(sswv_pkg::MIN_VAR_COUNT) |->
		o.variance == '0)
		else $error("variance nonzero below four samples");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !o.entry_valid |->
		o.read_time_us == '0 && !o.read_commit && o.read_stamp_ms == '0)
		else $error("read fields set without a valid entry");

endmodule

bind sample_store_with_variance_top sswv_checker #(.STORE_DEPTH(STORE_DEPTH)) u_sswv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
